[rtl/core/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg
// shared constants and types for the bipolar resistance averager
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int READS     = 11;
   localparam int ADC_BITS  = 10;
   localparam int REF_W     = 13;
   localparam int OUT_W     = 24;
   localparam int SUM_W     = 28;
   localparam int DIV_W     = SUM_W;
   localparam int DVS_W     = ADC_BITS;
   localparam int COUNT_W   = (READS > 1) ? $clog2(READS) : 1;
   localparam int DCNT_W    = $clog2(DIV_W);

   localparam logic [REF_W-1:0]   REF_RESET  = REF_W'(4700);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(READS - 1);
   localparam logic [DVS_W-1:0]   READS_DVS  = DVS_W'(READS);

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/bra_divider.sv]
// ----------------------------------------------------------------------------
// bra_divider
// shared restoring divider, one quotient bit per cycle on unsigned magnitudes
// ----------------------------------------------------------------------------
module bra_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bra_pkg::div_req_type div_req,
   output bra_pkg::div_rsp_type div_rsp
);
   import bra_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]   quot_ff, quot_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W:0]     rem_sh;
   logic [DVS_W:0]     rem_sub;
   logic               fits;

   assign rem_sh  = {rem_ff, quot_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign fits    = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W - 1);
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in  = cnt_ff - DCNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(div_req.start)) else $error("divider busy without start");

endmodule

[rtl/core/bipolar_resistance_averager.sv]
// ----------------------------------------------------------------------------
// bipolar_resistance_averager
// divider resistance per adc pair, averaged over two polarity groups
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one adc pair (supply level, sensor level); a request
//   is taken when req_valid is high and req_stall is low. req_stall is high
//   while a request is being worked on.
//   each request passes a multiply step, a divider load step, the shared
//   restoring divider and a step to take the quotient; req_stall stays high
//   throughout, so a new request is taken only after the last one is done.
//   the last request of a group runs the divider a second time for the
//   group average; the one closing the reversed group adds a step to load
//   the result register.
//   after every 2*READS requests one result appears on the rsp_ channel
//   (bias, compensated, zero_fault) and is held while rsp_stall is high;
//   a new request is taken meanwhile, and the block waits only when it has
//   a next result ready and the previous one is still not taken.
//   csr_write_enable writes the series resistor value; the user writes it
//   only while idle, which the block does not enforce. synchronous reset
//   clears the group counters, sums, result valid; resistor set to 4700 ohms.
// ----------------------------------------------------------------------------
module bipolar_resistance_averager (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bra_pkg::ADC_BITS-1:0]     req_supply_level,
   input  logic [bra_pkg::ADC_BITS-1:0]     req_sensor_level,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [bra_pkg::OUT_W-1:0] rsp_bias,
   output logic signed [bra_pkg::OUT_W-1:0] rsp_compensated,
   output logic                             rsp_zero_fault,
   input  logic                             csr_write_enable,
   input  logic [bra_pkg::REF_W-1:0]        csr_write_data
);
   import bra_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_START_R, S_DIV_R, S_START_A, S_DIV_A, S_EMIT
   } state_type;

   state_type                 state_ff;
   logic [REF_W-1:0]          ref_ff;
   logic signed [ADC_BITS:0]  diff_ff;
   logic [ADC_BITS-1:0]       sensor_ff;
   logic signed [OUT_W-1:0]   num_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [OUT_W-1:0]   first_ff;
   logic signed [OUT_W-1:0]   avg_ff;
   logic                      second_ff;
   logic                      fault_ff;
   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_bias_ff;
   logic signed [OUT_W-1:0]   rsp_comp_ff;
   logic                      rsp_fault_ff;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic                      req_take;
   logic                      rsp_free;
   logic signed [OUT_W+1:0]   product;
   logic [OUT_W-1:0]          num_mag;
   logic [SUM_W-1:0]          sum_mag;
   logic signed [OUT_W-1:0]   quot_s;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [OUT_W-1:0]   avg_in;
   logic signed [OUT_W:0]     pair_sum;
   logic signed [OUT_W:0]     pair_adj;
   logic signed [OUT_W-1:0]   bias_in;
   logic signed [OUT_W-1:0]   comp_in;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !(rsp_valid_ff && rsp_stall);

   assign product = $signed({2'b00, ref_ff}) * diff_ff;
   assign num_mag = num_ff[OUT_W-1] ? OUT_W'(-num_ff) : OUT_W'(num_ff);
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {{(DIV_W-OUT_W){1'b0}}, num_mag};
      div_req.divisor  = (sensor_ff == '0) ? DVS_W'(1) : sensor_ff;
      unique case (state_ff)
         S_START_R: div_req.start = 1'b1;
         S_START_A: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_mag;
            div_req.divisor  = READS_DVS;
         end
         default: ;
      endcase
   end

   // sign of quotient follows the dividend, truncating toward zero
   always_comb begin
      quot_s = OUT_W'(div_rsp.quotient);
      if (state_ff == S_DIV_R && num_ff[OUT_W-1]) begin
         quot_s = -OUT_W'(div_rsp.quotient);
      end else if (state_ff == S_DIV_A && sum_ff[SUM_W-1]) begin
         quot_s = -OUT_W'(div_rsp.quotient);
      end
   end

   assign sum_in   = sum_ff + SUM_W'(quot_s);
   assign avg_in   = quot_s;
   assign pair_sum = OUT_W'(0) + {first_ff[OUT_W-1], first_ff} + {avg_ff[OUT_W-1], avg_ff};
   assign pair_adj = pair_sum + (OUT_W+1)'(pair_sum[OUT_W]);
   assign comp_in  = OUT_W'(pair_adj >>> 1);
   assign bias_in  = first_ff - avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_ff       <= REF_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         first_ff     <= '0;
         second_ff    <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ref_ff <= csr_write_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  diff_ff   <= $signed({1'b0, req_supply_level})
                             - $signed({1'b0, req_sensor_level});
                  sensor_ff <= req_sensor_level;
                  if (req_sensor_level == '0) begin
                     fault_ff <= 1'b1;
                  end
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               num_ff   <= OUT_W'(product);
               state_ff <= S_START_R;
            end
            S_START_R: state_ff <= S_DIV_R;
            S_DIV_R: begin
               if (div_rsp.done) begin
                  if (count_ff == COUNT_LAST) begin
                     sum_ff   <= sum_in;
                     state_ff <= S_START_A;
                  end else begin
                     sum_ff   <= sum_in;
                     count_ff <= count_ff + COUNT_W'(1);
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_START_A: state_ff <= S_DIV_A;
            S_DIV_A: begin
               if (div_rsp.done) begin
                  count_ff <= '0;
                  sum_ff   <= '0;
                  if (second_ff) begin
                     avg_ff   <= avg_in;
                     state_ff <= S_EMIT;
                  end else begin
                     first_ff  <= avg_in;
                     second_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bias_ff  <= bias_in;
                  rsp_comp_ff  <= comp_in;
                  rsp_fault_ff <= fault_ff;
                  fault_ff     <= 1'b0;
                  second_ff    <= 1'b0;
                  first_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   bra_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bias        = rsp_bias_ff;
   assign rsp_compensated = rsp_comp_ff;
   assign rsp_zero_fault  = rsp_fault_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LAST) else $error("pair count past group size");
   a_take_mul: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_MUL) else $error("request not moved to multiply");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_free) |=> rsp_valid_ff) else $error("result lost");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_R || state_ff == S_DIV_A) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on idle divider");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench for the bipolar resistance averager
// ----------------------------------------------------------------------------
// adc pairs go in over the req_ channel and group results come out over the
// rsp_ channel. every accepted request is folded into a local predictor that
// keeps its own group sums and averages. each result is compared field by
// field with the oldest predicted one. a short table of full-scale and
// balanced pairs runs first at the reset resistor value. then eight random
// phases follow, each with its own resistor value (extremes and zero among
// them), written while the block is drained. the sender and receiver idle
// at random, and one phase holds the receiver off long enough that the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bra_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 3000;
   localparam int PHASE_PAIRS    = 200;
   localparam int NUM_PHASES     = 8;
   localparam int LEVEL_MAX      = (1 << ADC_BITS) - 1;
   localparam int REF_MAX        = (1 << REF_W) - 1;

   typedef logic [ADC_BITS-1:0] level_type;
   typedef logic [REF_W-1:0]    ohms_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] bias;
      logic signed [OUT_W-1:0] compensated;
      logic                    zero_fault;
   } reading_type;

   typedef struct packed {
      level_type supply;
      level_type sensor;
      logic      known;
   } pair_row_type;

   // full scale with a zero sensor, then balanced pairs that read zero ohms
   localparam pair_row_type DIRECTED_PAIRS [2*READS] = '{
      '{10'd1023, 10'd0,    1'b0}, '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd0,    1'b0}, '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd0,    1'b0}, '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd0,    1'b0}, '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd0,    1'b0}, '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd0,    1'b0},
      '{10'd1023, 10'd1023, 1'b0}, '{10'd0,    10'd0,    1'b0},
      '{10'd1,    10'd1,    1'b0}, '{10'd512,  10'd512,  1'b0},
      '{10'd341,  10'd341,  1'b0}, '{10'd682,  10'd682,  1'b0},
      '{10'd2,    10'd2,    1'b0}, '{10'd4,    10'd4,    1'b0},
      '{10'd8,    10'd8,    1'b0}, '{10'd16,   10'd16,   1'b0},
      '{10'd1023, 10'd1023, 1'b1}
   };

   localparam reading_type DIRECTED_READING = '{
      bias:        24'sd4808100,
      compensated: 24'sd2404050,
      zero_fault:  1'b1
   };

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   level_type               req_supply_level = '0;
   level_type               req_sensor_level = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic signed [OUT_W-1:0] rsp_bias;
   logic signed [OUT_W-1:0] rsp_compensated;
   logic                    rsp_zero_fault;
   logic                    csr_write_enable = 1'b0;
   ohms_type                csr_write_data   = '0;

   // predictor state
   ohms_type    reference_ohms = REF_RESET;
   int          pairs_in_group = 0;
   longint      group_sum      = 0;
   longint      first_average  = 0;
   bit          fault_seen     = 1'b0;
   bit          second_group   = 1'b0;
   reading_type due_readings [$];

   int failures      = 0;
   int idle_cycles   = 0;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   bipolar_resistance_averager DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_supply_level (req_supply_level),
      .req_sensor_level (req_sensor_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bias         (rsp_bias),
      .rsp_compensated  (rsp_compensated),
      .rsp_zero_fault   (rsp_zero_fault),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   function automatic void accumulate_pair(input level_type supply, input level_type sensor,
                                           input logic known);
      longint ohms_l;
      longint supply_l;
      longint sensor_l;
      longint divisor;
      longint group_average;
      reading_type reading;
      ohms_l   = reference_ohms;
      supply_l = supply;
      sensor_l = sensor;
      divisor  = sensor_l;
      if (sensor_l == 0) begin
         fault_seen = 1'b1;
         divisor    = 1;
      end
      group_sum += (ohms_l * (supply_l - sensor_l)) / divisor;
      pairs_in_group++;
      if (pairs_in_group < READS) return;
      group_average  = group_sum / READS;
      pairs_in_group = 0;
      group_sum      = 0;
      if (!second_group) begin
         first_average = group_average;
         second_group  = 1'b1;
         return;
      end
      reading.bias        = OUT_W'(first_average - group_average);
      reading.compensated = OUT_W'((first_average + group_average) / 2);
      reading.zero_fault  = fault_seen;
      due_readings.push_back(known ? DIRECTED_READING : reading);
      second_group  = 1'b0;
      fault_seen    = 1'b0;
      first_average = 0;
   endfunction

   function automatic level_type pick_level(input int zero_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < zero_pct) return '0;
      if (roll < zero_pct + 8) return level_type'(LEVEL_MAX);
      if (roll < zero_pct + 12) return level_type'(1);
      return level_type'($urandom_range(LEVEL_MAX));
   endfunction

   function automatic ohms_type reference_for_phase(input int phase);
      case (phase)
         0, 6:    return ohms_type'(REF_MAX);
         1:       return ohms_type'(1);
         3:       return '0;
         4:       return REF_RESET;
         default: return ohms_type'($urandom_range(REF_MAX, 1));
      endcase
   endfunction

   task automatic send_pair(input level_type supply, input level_type sensor,
                            input logic known);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_supply_level <= supply;
      req_sensor_level <= sensor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_pair(supply, sensor, known);
   endtask

   task automatic wait_until_drained();
      while (due_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reference(input ohms_type value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reference_ohms = value;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_readings.size() == 0) begin
               $display("%0t: unexpected result, bias %0d compensated %0d zero_fault %0b",
                        $time, rsp_bias, rsp_compensated, rsp_zero_fault);
               failures++;
            end else begin
               want = due_readings.pop_front();
               check_field("bias", want.bias, rsp_bias);
               check_field("compensated", want.compensated, rsp_compensated);
               check_field("zero_fault", want.zero_fault, rsp_zero_fault);
            end
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      level_type supply;
      level_type sensor;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 6;
      rsp_stall_pct = 49;
      for (int i = 0; i < 2*READS; i++) begin
         send_pair(DIRECTED_PAIRS[i].supply, DIRECTED_PAIRS[i].sensor,
                   DIRECTED_PAIRS[i].known);
      end
      req_valid <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_until_drained();
         write_reference(reference_for_phase(phase));
         if (phase < 3) begin
            req_gap_pct   = 6;
            rsp_stall_pct = 49;
         end else if (phase < 6) begin
            req_gap_pct   = 49;
            rsp_stall_pct = 6;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            supply = pick_level(8);
            sensor = ($urandom_range(15) == 0) ? supply : pick_level(2);
            send_pair(supply, sensor, 1'b0);
            // back the block up behind a stalled receiver
            if (phase == 1 && n == 20) hold_requests++;
         end
         req_valid <= 1'b0;
      end

      wait_until_drained();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
